### hw/rtl/dll_pkg.sv
// Package: shared types and constants for the linked list engine.
`timescale 1ns / 1ps
package dll_pkg;
  localparam int CAPACITY = 32;
  localparam int DUMP_LIMIT = 32;
  localparam int AW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [AW-1:0] NIL = AW'(CAPACITY);

  typedef enum logic [3:0] {
    ACT_INS_HEAD = 4'd0, ACT_INS_TAIL = 4'd1, ACT_INS_POS = 4'd2,
    ACT_DEL_HEAD = 4'd3, ACT_DEL_TAIL = 4'd4, ACT_DEL_POS = 4'd5,
    ACT_SEARCH = 4'd6, ACT_DUMP_FWD = 4'd7, ACT_DUMP_BACK = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BAD_POS = 3'd2,
    ST_RANGE = 3'd3, ST_NOT_FOUND = 3'd4, ST_FULL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_INS_A, S_INS_B, S_INS_C, S_DEL_A, S_DEL_B,
    S_SRCH, S_DUMP, S_OUT
  } state_t;
endpackage

### hw/rtl/dll_ram.sv
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
module dll_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/doubly_linked_list_engine_core.sv
// Top level: bounded doubly linked list engine over node memories.
//
//  channel | dir | tdata fields (low bit up)           | tuser/tlast
//  in_     | in  | action[3:0] value[35:4] pos[43:36]   | -
//  out_    | out | status[2:0] element[34:3] index[42:35] | tlast = last
//
// Head/tail ops need no walk; positional ops, search and dumps walk one node a
// cycle through the link memories (a dump waits while the output register is held).
// After reset the forward-link memory is swept to build the free chain, and
// in_tready stays low during the sweep. A stalled result holds in the output
// register; the engine waits there before the next word.
`timescale 1ns / 1ps
module doubly_linked_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // action[3:0], value[35:4], position[43:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], element[34:3], index[42:35]
  output logic        out_tlast
);
  import dll_pkg::*;

  // memories: values, forward links, backward links
  logic          vwe, fwe, bwe;
  logic [IW-1:0] vwa, fwa, bwa, ra;
  logic [31:0]   vwd, vrd;
  logic [AW-1:0] fwd, bwdd, frd, brd;

  dll_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_val (
    .clk, .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(ra), .rdata(vrd));
  dll_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_fwd (
    .clk, .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(ra), .rdata(frd));
  dll_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_bwd (
    .clk, .we(bwe), .waddr(bwa), .wdata(bwdd), .raddr(ra), .rdata(brd));

  state_t state_r, state_nxt;
  logic          init_r, init_nxt;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    act_r, act_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [AW-1:0] cur_r, cur_nxt;     // node being walked / cut
  logic [AW-1:0] nn_r, nn_nxt;       // newly taken node
  logic [AW-1:0] pred_r, pred_nxt;   // node after which to insert
  logic [8:0]    k_r, k_nxt;         // walk step counter
  logic [2:0]    ost_r, ost_nxt;
  logic [31:0]   oel_r, oel_nxt;
  logic [7:0]    oix_r, oix_nxt;
  logic          olast_r, olast_nxt, ov_r, ov_nxt;
  logic          done_r, done_nxt;   // result in flight ends the request

  logic [3:0]  in_act;
  logic [31:0] in_val;
  logic [7:0]  in_pos;
  assign in_act = in_tdata[3:0];
  assign in_val = in_tdata[35:4];
  assign in_pos = in_tdata[43:36];

  // take a new word only once the previous result leaves the output register
  assign in_tready  = (state_r == S_IDLE) && !init_r && (!ov_r || out_tready);
  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, oix_r, oel_r, ost_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; init_r <= 1'b1; head_r <= NIL; tail_r <= NIL;
      free_r <= '0; cnt_r <= '0; ov_r <= 1'b0; cur_r <= '0;
    end else begin
      state_r <= state_nxt; init_r <= init_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; free_r <= free_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      cur_r <= cur_nxt;
    end
    act_r <= act_nxt; val_r <= val_nxt; pos_r <= pos_nxt; nn_r <= nn_nxt;
    pred_r <= pred_nxt; k_r <= k_nxt; ost_r <= ost_nxt; oel_r <= oel_nxt;
    oix_r <= oix_nxt; olast_r <= olast_nxt; done_r <= done_nxt;
  end

  always_comb begin
    state_nxt = state_r; init_nxt = init_r; head_nxt = head_r; tail_nxt = tail_r;
    free_nxt = free_r; cnt_nxt = cnt_r; act_nxt = act_r; val_nxt = val_r;
    pos_nxt = pos_r; cur_nxt = cur_r; nn_nxt = nn_r; pred_nxt = pred_r;
    k_nxt = k_r; ost_nxt = ost_r; oel_nxt = oel_r; oix_nxt = oix_r;
    olast_nxt = olast_r; ov_nxt = ov_r; done_nxt = done_r;
    vwe = 1'b0; fwe = 1'b0; bwe = 1'b0;
    vwa = '0; fwa = '0; bwa = '0; vwd = val_r; fwd = '0; bwdd = '0;
    ra = cur_r[IW-1:0];

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (init_r) begin
          // sweep the free chain: entry i links to i+1
          fwe = 1'b1; fwa = cur_r[IW-1:0]; fwd = cur_r + AW'(1);
          cur_nxt = cur_r + AW'(1);
          if (cur_r == AW'(CAPACITY - 1)) init_nxt = 1'b0;
        end else if (in_tvalid && in_tready) begin
          act_nxt = in_act; val_nxt = in_val; pos_nxt = in_pos;
          ost_nxt = ST_OK; oel_nxt = '0; oix_nxt = '0; olast_nxt = 1'b1;
          k_nxt = '0; done_nxt = 1'b1; state_nxt = S_OUT;
          ra = free_r[IW-1:0];
          priority case (in_act)
            ACT_INS_HEAD, ACT_INS_TAIL: begin
              if (cnt_r == AW'(CAPACITY)) ost_nxt = ST_FULL;
              else begin pred_nxt = NIL; cur_nxt = free_r; state_nxt = S_INS_A; end
            end
            ACT_INS_POS: begin
              if (in_pos == 8'd0) ost_nxt = ST_BAD_POS;
              else if (head_r != NIL && 9'(in_pos) > 9'(cnt_r) + 9'd1)
                ost_nxt = ST_RANGE;
              else if (cnt_r == AW'(CAPACITY)) ost_nxt = ST_FULL;
              else if (in_pos == 8'd1 || head_r == NIL) begin
                act_nxt = ACT_INS_HEAD; cur_nxt = free_r; state_nxt = S_INS_A;
              end else begin
                // walk pos-2 steps from head
                cur_nxt = head_r; k_nxt = 9'(in_pos) - 9'd2;
                ra = head_r[IW-1:0]; state_nxt = S_WALK;
              end
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
              if (head_r == NIL) ost_nxt = ST_EMPTY;
              else begin
                cur_nxt = (in_act == ACT_DEL_HEAD) ? head_r : tail_r;
                ra = cur_nxt[IW-1:0]; state_nxt = S_DEL_A;
              end
            end
            ACT_DEL_POS: begin
              if (head_r == NIL || in_pos == 8'd0) ost_nxt = ST_BAD_POS;
              else if (9'(in_pos) > 9'(cnt_r)) ost_nxt = ST_RANGE;
              else begin
                cur_nxt = head_r; k_nxt = 9'(in_pos) - 9'd1;
                ra = head_r[IW-1:0]; state_nxt = S_WALK;
              end
            end
            ACT_SEARCH: begin
              ost_nxt = ST_NOT_FOUND;
              if (head_r != NIL) begin
                cur_nxt = head_r; k_nxt = 9'd1; ra = head_r[IW-1:0];
                state_nxt = S_SRCH;
              end
            end
            ACT_DUMP_FWD, ACT_DUMP_BACK: begin
              if (head_r == NIL) ost_nxt = ST_EMPTY;
              else begin
                cur_nxt = (in_act == ACT_DUMP_FWD) ? head_r : tail_r;
                ra = cur_nxt[IW-1:0]; state_nxt = S_DUMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        // frd holds forward link of cur_r
        if (k_r == 9'd0) begin
          if (act_r == ACT_DEL_POS) begin
            ra = cur_r[IW-1:0]; state_nxt = S_DEL_A;
          end else begin
            pred_nxt = cur_r; cur_nxt = free_r; ra = free_r[IW-1:0];
            state_nxt = S_INS_A;
          end
        end else begin
          cur_nxt = frd; ra = frd[IW-1:0]; k_nxt = k_r - 9'd1;
        end
      end
      S_INS_A: begin
        // frd = next free; nn = cur_r (taken node); also read pred's link
        nn_nxt = cur_r; free_nxt = frd; cnt_nxt = cnt_r + AW'(1);
        vwe = 1'b1; vwa = cur_r[IW-1:0];
        ra = pred_r[IW-1:0];
        state_nxt = S_INS_B;
      end
      S_INS_B: begin
        // frd = forward link of pred (valid when inserting after pred)
        fwe = 1'b1; fwa = nn_r[IW-1:0]; bwe = 1'b1; bwa = nn_r[IW-1:0];
        state_nxt = S_OUT;
        unique case (act_r)
          ACT_INS_HEAD: begin
            fwd = head_r; bwdd = NIL; head_nxt = nn_r;
            if (head_r == NIL) tail_nxt = nn_r;
            else begin cur_nxt = head_r; pred_nxt = nn_r; state_nxt = S_INS_C; end
          end
          ACT_INS_TAIL: begin
            fwd = NIL; bwdd = tail_r; tail_nxt = nn_r;
            if (tail_r == NIL) head_nxt = nn_r;
            else begin cur_nxt = tail_r; pred_nxt = nn_r; state_nxt = S_INS_C; end
          end
          default: begin
            fwd = frd; bwdd = pred_r; cur_nxt = frd;
            state_nxt = S_INS_C;
          end
        endcase
      end
      S_INS_C: begin
        state_nxt = S_OUT;
        unique case (act_r)
          ACT_INS_HEAD: begin bwe = 1'b1; bwa = cur_r[IW-1:0]; bwdd = nn_r; end
          ACT_INS_TAIL: begin fwe = 1'b1; fwa = cur_r[IW-1:0]; fwd = nn_r; end
          default: begin
            // q = cur_r; link q back to new node, pred forward to it
            fwe = 1'b1; fwa = pred_r[IW-1:0]; fwd = nn_r;
            if (cur_r != NIL) begin bwe = 1'b1; bwa = cur_r[IW-1:0]; bwdd = nn_r; end
            else tail_nxt = nn_r;
          end
        endcase
      end
      S_DEL_A: begin
        // frd/brd = links of cur_r: fix p.fwd or head, n.bwd or tail
        pred_nxt = brd; nn_nxt = frd;
        if (brd != NIL) begin fwe = 1'b1; fwa = brd[IW-1:0]; fwd = frd; end
        else head_nxt = frd;
        if (frd != NIL) begin bwe = 1'b1; bwa = frd[IW-1:0]; bwdd = brd; end
        else tail_nxt = brd;
        state_nxt = S_DEL_B;
      end
      S_DEL_B: begin
        // return node to free chain
        fwe = 1'b1; fwa = cur_r[IW-1:0]; fwd = free_r; free_nxt = cur_r;
        if (cnt_r != '0) cnt_nxt = cnt_r - AW'(1);
        state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (vrd == val_r) begin
          ost_nxt = ST_OK; oix_nxt = k_r[7:0]; state_nxt = S_OUT;
        end else if (frd == NIL || k_r == 9'(CAPACITY)) state_nxt = S_OUT;
        else begin
          cur_nxt = frd; ra = frd[IW-1:0]; k_nxt = k_r + 9'd1;
        end
      end
      S_DUMP: begin
        // hold until the output register is free, then emit one element
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ost_nxt = ST_OK; oel_nxt = vrd; oix_nxt = '0;
          cur_nxt = (act_r == ACT_DUMP_FWD) ? frd : brd;
          olast_nxt = (cur_nxt == NIL) || (k_r == 9'(DUMP_LIMIT - 1));
          k_nxt = k_r + 9'd1;
          ra = cur_nxt[IW-1:0];
          if (olast_nxt) state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = done_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### dv/tb.sv
// Testbench: random and directed list requests checked against a list model.
`timescale 1ns / 1ps
module tb;
  import dll_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] element;
    logic [7:0]  index;
    logic        last;
  } result_t;

  class list_scoreboard;
    logic [31:0] vals[$];
    result_t pending[$];
    int errors;

    function automatic void note_request(logic [3:0] act, logic [31:0] v, logic [7:0] pos);
      result_t r;
      int n;
      n = vals.size();
      r = '{ST_OK, 32'd0, 8'd0, 1'b1};
      case (act)
        ACT_INS_HEAD, ACT_INS_TAIL: begin
          if (n >= CAPACITY) r.status = ST_FULL;
          else if (act == ACT_INS_HEAD) vals.push_front(v);
          else vals.push_back(v);
        end
        ACT_INS_POS: begin
          if (pos == 0) r.status = ST_BAD_POS;
          else if (n > 0 && pos > n + 1) r.status = ST_RANGE;
          else if (n >= CAPACITY) r.status = ST_FULL;
          else if (pos == 1 || n == 0) vals.push_front(v);
          else vals.insert(pos - 1, v);
        end
        ACT_DEL_HEAD: if (n == 0) r.status = ST_EMPTY; else vals.pop_front();
        ACT_DEL_TAIL: if (n == 0) r.status = ST_EMPTY; else vals.pop_back();
        ACT_DEL_POS: begin
          if (n == 0 || pos == 0) r.status = ST_BAD_POS;
          else if (pos > n) r.status = ST_RANGE;
          else vals.delete(pos - 1);
        end
        ACT_SEARCH: begin
          r.status = ST_NOT_FOUND;
          foreach (vals[i]) if (vals[i] == v) begin
            r.status = ST_OK;
            r.index = 8'(i + 1);
            break;
          end
        end
        ACT_DUMP_FWD, ACT_DUMP_BACK: begin
          if (n == 0) r.status = ST_EMPTY;
          else begin
            for (int i = 0; i < n && i < DUMP_LIMIT; i++) begin
              r.element = (act == ACT_DUMP_FWD) ? vals[i] : vals[n - 1 - i];
              r.last = (i == n - 1) || (i == DUMP_LIMIT - 1);
              pending.push_back(r);
            end
            return;
          end
        end
        default: return;  // unknown action: no result
      endcase
      pending.push_back(r);
    endfunction

    function automatic void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  list_scoreboard sb;
  longint cycles;
  bit quiet;  // no idling in the closing part of the run

  doubly_linked_list_engine_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: worst-case request time plus stalls, taken many times over.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, check each accepted word.
  initial begin
    int gap;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_result('{status_t'(out_tdata[2:0]), out_tdata[34:3], out_tdata[42:35],
                          out_tlast});
      if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
      end
    end
  end

  // Leaves in_tvalid high after the accepting edge; the next call or the
  // caller drops it.
  task automatic send_request(logic [3:0] act, logic [31:0] v, logic [7:0] pos);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, pos, v, act};
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, v, pos);
  endtask

  task automatic random_request();
    int r;
    int n;
    logic [31:0] v;
    n = sb.vals.size();
    r = $urandom_range(0, 99);
    // draw values from a small pool often so searches hit
    v = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 15)) : $urandom;
    if (r < 20)      send_request(ACT_INS_HEAD, v, 8'($urandom));
    else if (r < 40) send_request(ACT_INS_TAIL, v, 8'($urandom));
    else if (r < 55) send_request(ACT_INS_POS, v,
                                  8'(($urandom_range(0, 9) == 0) ? $urandom
                                                                 : $urandom_range(0, n + 2)));
    else if (r < 62) send_request(ACT_DEL_HEAD, v, 8'($urandom));
    else if (r < 69) send_request(ACT_DEL_TAIL, v, 8'($urandom));
    else if (r < 79) send_request(ACT_DEL_POS, v,
                                  8'(($urandom_range(0, 9) == 0) ? $urandom
                                                                 : $urandom_range(0, n + 1)));
    else if (r < 89) send_request(ACT_SEARCH, v, 8'($urandom));
    else if (r < 93) send_request(ACT_DUMP_FWD, v, 8'($urandom));
    else if (r < 97) send_request(ACT_DUMP_BACK, v, 8'($urandom));
    else             send_request(4'($urandom_range(9, 15)), v, 8'($urandom));
  endtask

  initial begin
    int wait_cnt;
    sb = new();
    quiet = 0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, extremes, position checks, unknown actions.
    send_request(ACT_DEL_HEAD, 32'd0, 8'd0);
    send_request(ACT_DEL_TAIL, 32'd0, 8'd0);
    send_request(ACT_DEL_POS, 32'd0, 8'd1);
    send_request(ACT_SEARCH, 32'd0, 8'd0);
    send_request(ACT_DUMP_FWD, 32'd0, 8'd0);
    send_request(ACT_DUMP_BACK, 32'd0, 8'd0);
    send_request(ACT_INS_POS, 32'h8000_0000, 8'd200);  // empty list goes to head
    send_request(ACT_INS_POS, 32'h7FFF_FFFF, 8'd0);
    send_request(ACT_INS_POS, 32'd5, 8'd255);
    send_request(ACT_INS_TAIL, 32'hFFFF_FFFF, 8'hFF);
    send_request(ACT_INS_HEAD, 32'h7FFF_FFFF, 8'd0);
    send_request(ACT_INS_POS, 32'h5555_AAAA, 8'd4);
    send_request(ACT_INS_POS, 32'hAAAA_5555, 8'd2);
    send_request(ACT_SEARCH, 32'hFFFF_FFFF, 8'd0);
    send_request(ACT_DUMP_FWD, 32'd0, 8'd0);
    send_request(ACT_DUMP_BACK, 32'd0, 8'd0);
    send_request(ACT_DEL_POS, 32'd0, 8'd0);
    send_request(ACT_DEL_POS, 32'd0, 8'd9);
    send_request(ACT_DEL_POS, 32'd0, 8'd3);
    send_request(4'd9, 32'd0, 8'd0);
    send_request(4'd15, 32'hFFFF_FFFF, 8'hFF);
    // Fill to capacity and beyond, then dump a full list.
    for (int i = 0; i < CAPACITY + 2; i++) send_request(ACT_INS_TAIL, $urandom, 8'd0);
    send_request(ACT_INS_HEAD, 32'd1, 8'd0);
    send_request(ACT_INS_POS, 32'd1, 8'd3);
    send_request(ACT_DUMP_FWD, 32'd0, 8'd0);
    send_request(ACT_DUMP_BACK, 32'd0, 8'd0);
    // Hold the sender until every expected word has arrived.
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < CAPACITY + 2; i++) send_request(ACT_DEL_HEAD, 32'd0, 8'd0);

    for (int i = 0; i < 330; i++) begin
      if (i == 280) quiet = 1;
      random_request();
    end
    in_tvalid <= 1'b0;

    wait_cnt = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    while (wait_cnt < 100) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
